FILE: hdl/cttog_pkg.sv
// shared types, constants and helpers for the capacitive touch toggle
// no dependencies; imported by every module of the block
package cttog_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int EDGE_W     = 8;
    localparam int TICK_W     = 32;
    localparam int ROUND_W    = 8;
    localparam int HZ_W       = 32;
    localparam int FRAC_W     = 16;
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 32;
    localparam int PROD_W     = HZ_W + FRAC_W;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [EDGE_W-1:0]  EDGES_RST   = 8'd10;
    localparam logic [ROUND_W-1:0] ROUNDS_RST  = 8'd10;
    localparam logic [HZ_W-1:0]    CLOCK_RST   = 32'd32000000;
    localparam logic [FRAC_W-1:0]  TOUCH_RST   = 16'd55706;
    localparam logic [FRAC_W-1:0]  RELEASE_RST = 16'd58982;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGES   = 3'd0,
        CFG_ROUNDS  = 3'd1,
        CFG_CLOCK   = 3'd2,
        CFG_TOUCH   = 3'd3,
        CFG_RELEASE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic pin_level;
    } t_in_item;

    typedef struct packed {
        logic            pull_up_on;
        logic            led_on;
        logic            measure_done;
        logic [HZ_W-1:0] measured_hz;
        logic            baseline_ready;
        logic [HZ_W-1:0] baseline_hz;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_item;

    typedef struct packed {
        logic [EDGE_W-1:0]  edges_per_measure;
        logic [ROUND_W-1:0] calibration_rounds;
        logic [HZ_W-1:0]    clock_hz;
        logic [FRAC_W-1:0]  touch_fraction_q16;
        logic [FRAC_W-1:0]  release_fraction_q16;
    } t_cfg_regs;

    typedef struct packed {
        logic              pull_up_on;
        logic              measure_done;
        logic [EDGE_W-1:0] edge_count;
        logic [TICK_W-1:0] tick_count;
    } t_q_entry;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_FREQ_GO,
        BK_FREQ_WAIT,
        BK_SUM,
        BK_AVG_GO,
        BK_AVG_WAIT,
        BK_TOUCH,
        BK_RELEASE,
        BK_COMPARE,
        BK_EMIT
    } t_back_state;

    function automatic logic [HZ_W-1:0] sat_hz(input logic [DIV_NUM_W-1:0] v);
        logic [HZ_W-1:0] r;
        r = (|v[DIV_NUM_W-1:HZ_W]) ? {HZ_W{1'b1}} : v[HZ_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/cttog_stream_if.sv
// valid/ready channel carrying one payload struct per beat
// payload type is supplied by the instantiating level (types from cttog_pkg)
interface cttog_stream_if #(parameter type t_payload = logic) ();

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/cttog_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on cttog_pkg for widths and request/response structs
module cttog_div
    import cttog_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_NUM_W-1:0] n_quo;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        n_quo  = {r_quo[DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the numerator shifts out
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/cttog_front.sv
// front end: edge detection, pull select, edge and tick tallies
// depends on cttog_pkg; pushes one classified entry per accepted sample
module cttog_front
    import cttog_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_level,
    output logic              o_in_ready,
    input  logic [EDGE_W-1:0] i_edges_per_measure,
    output logic              o_push_valid,
    output t_q_entry          o_push_entry,
    input  logic              i_push_ready
);

    logic              r_last;
    logic              r_pull;
    logic [EDGE_W-1:0] r_edge;
    logic [TICK_W-1:0] r_tick;

    logic              n_pull;
    logic [EDGE_W-1:0] n_edge;
    logic [EDGE_W-1:0] edge_inc;
    logic [TICK_W-1:0] n_tick;
    logic [EDGE_W-1:0] need_edges;
    logic              done;
    logic              accept;

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign accept       = i_in_valid && i_push_ready;

    always_comb begin
        need_edges = (i_edges_per_measure == '0) ? EDGE_W'(1) : i_edges_per_measure;
        n_tick     = (r_tick == '1) ? r_tick : r_tick + 1'b1;
        edge_inc   = (r_edge == '1) ? r_edge : r_edge + 1'b1;
        n_pull     = r_pull;
        n_edge     = r_edge;
        done       = 1'b0;
        if (!i_in_level && r_last) begin
            n_pull = 1'b1;
        end else if (i_in_level && !r_last) begin
            n_pull = 1'b0;
            n_edge = edge_inc;
            done   = (edge_inc >= need_edges);
        end
        o_push_entry.pull_up_on   = n_pull;
        o_push_entry.measure_done = done;
        o_push_entry.edge_count   = edge_inc;
        o_push_entry.tick_count   = n_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b1;
            r_pull <= 1'b0;
            r_edge <= '0;
            r_tick <= '0;
        end else if (accept) begin
            r_last <= i_in_level;
            r_pull <= n_pull;
            r_edge <= done ? '0 : n_edge;
            r_tick <= done ? '0 : n_tick;
        end
    end

endmodule

FILE: hdl/cttog_queue.sv
// short fifo between front and back ends
// depends on cttog_pkg for the entry type
module cttog_queue
    import cttog_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    input  t_q_entry i_push_entry,
    output logic     o_push_ready,
    output logic     o_pop_valid,
    output t_q_entry o_pop_entry,
    input  logic     i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count + CNT_W'(do_push) - CNT_W'(do_pop))))
        else $error("queue fill count lost track of beats");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue empty but pointers differ");
`endif

endmodule

FILE: hdl/cttog_back.sv
// back end: frequency divide, calibration average, touch/release test,
// output register; depends on cttog_pkg and a shared cttog_div
module cttog_back
    import cttog_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_regs i_cfg,
    input  logic      i_pop_valid,
    input  t_q_entry  i_pop_entry,
    output logic      o_pop_ready,
    output t_div_req  o_div_req,
    input  t_div_rsp  i_div_rsp,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    t_back_state r_state, n_state;

    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    logic                 r_pull, n_pull;
    logic [EDGE_W-1:0]    r_edges, n_edges;
    logic [TICK_W-1:0]    r_ticks, n_ticks;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [HZ_W-1:0]      r_hz, n_hz;
    logic [DIV_NUM_W-1:0] r_freq_sum, n_freq_sum;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic [HZ_W-1:0]      r_baseline, n_baseline;
    logic                 r_calibrating, n_calibrating;
    logic [HZ_W-1:0]      r_prev_hz, n_prev_hz;
    logic                 r_toggle, n_toggle;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic                 r_touched, n_touched;
    logic                 r_ready, n_ready;

    logic                 slot_free;
    logic                 load_out;
    logic [ROUND_W-1:0]   need_rounds;
    logic [ROUND_W-1:0]   round_inc;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign need_rounds = (i_cfg.calibration_rounds == '0) ? ROUND_W'(1)
                                                          : i_cfg.calibration_rounds;
    assign round_inc   = (r_round == '1) ? r_round : r_round + 1'b1;

    always_comb begin
        n_state       = r_state;
        n_out         = r_out;
        n_pull        = r_pull;
        n_edges       = r_edges;
        n_ticks       = r_ticks;
        n_num         = r_num;
        n_hz          = r_hz;
        n_freq_sum    = r_freq_sum;
        n_round       = r_round;
        n_baseline    = r_baseline;
        n_calibrating = r_calibrating;
        n_prev_hz     = r_prev_hz;
        n_toggle      = r_toggle;
        n_prod        = r_prod;
        n_touched     = r_touched;
        n_ready       = r_ready;
        load_out      = 1'b0;
        o_pop_ready   = 1'b0;
        o_div_req     = '{start: 1'b0, num: r_num, den: r_ticks};

        case (r_state)
            BK_IDLE: begin
                if (i_pop_valid && slot_free) begin
                    o_pop_ready = 1'b1;
                    if (i_pop_entry.measure_done) begin
                        n_pull  = i_pop_entry.pull_up_on;
                        n_edges = i_pop_entry.edge_count;
                        n_ticks = i_pop_entry.tick_count;
                        n_state = BK_MUL;
                    end else begin
                        // plain tick passes straight to the output register
                        load_out = 1'b1;
                        n_out    = '{pull_up_on: i_pop_entry.pull_up_on,
                                     led_on: r_toggle,
                                     measure_done: 1'b0,
                                     measured_hz: '0,
                                     baseline_ready: 1'b0,
                                     baseline_hz: r_baseline};
                    end
                end
            end
            BK_MUL: begin
                n_num   = DIV_NUM_W'(i_cfg.clock_hz) * DIV_NUM_W'(r_edges);
                n_state = BK_FREQ_GO;
            end
            BK_FREQ_GO: begin
                o_div_req.start = 1'b1;
                n_state         = BK_FREQ_WAIT;
            end
            BK_FREQ_WAIT: begin
                if (i_div_rsp.done) begin
                    n_hz    = sat_hz(i_div_rsp.quotient);
                    n_state = r_calibrating ? BK_SUM : BK_TOUCH;
                end
            end
            BK_SUM: begin
                n_freq_sum = r_freq_sum + DIV_NUM_W'(r_hz);
                n_round    = round_inc;
                n_state    = (round_inc >= need_rounds) ? BK_AVG_GO : BK_EMIT;
            end
            BK_AVG_GO: begin
                o_div_req = '{start: 1'b1, num: r_freq_sum, den: DIV_DEN_W'(need_rounds)};
                n_state   = BK_AVG_WAIT;
            end
            BK_AVG_WAIT: begin
                if (i_div_rsp.done) begin
                    n_baseline    = sat_hz(i_div_rsp.quotient);
                    n_calibrating = 1'b0;
                    n_ready       = 1'b1;
                    n_state       = BK_EMIT;
                end
            end
            BK_TOUCH: begin
                n_prod  = PROD_W'(r_baseline) * PROD_W'(i_cfg.touch_fraction_q16);
                n_state = BK_RELEASE;
            end
            BK_RELEASE: begin
                n_touched = ({r_hz, {FRAC_W{1'b0}}} <= r_prod);
                n_prod    = PROD_W'(r_baseline) * PROD_W'(i_cfg.release_fraction_q16);
                n_state   = BK_COMPARE;
            end
            BK_COMPARE: begin
                // toggle only when the previous reading was above release level
                if (r_touched && ({r_prev_hz, {FRAC_W{1'b0}}} > r_prod)) begin
                    n_toggle = !r_toggle;
                end
                n_prev_hz = r_hz;
                n_state   = BK_EMIT;
            end
            BK_EMIT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_out    = '{pull_up_on: r_pull,
                                 led_on: r_toggle,
                                 measure_done: 1'b1,
                                 measured_hz: r_hz,
                                 baseline_ready: r_ready,
                                 baseline_hz: r_baseline};
                    n_ready  = 1'b0;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_out_valid   <= 1'b0;
            r_freq_sum    <= '0;
            r_round       <= '0;
            r_baseline    <= '0;
            r_calibrating <= 1'b1;
            r_prev_hz     <= '0;
            r_toggle      <= 1'b0;
            r_ready       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_freq_sum    <= n_freq_sum;
            r_round       <= n_round;
            r_baseline    <= n_baseline;
            r_calibrating <= n_calibrating;
            r_prev_hz     <= n_prev_hz;
            r_toggle      <= n_toggle;
            r_ready       <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_pull    <= n_pull;
        r_edges   <= n_edges;
        r_ticks   <= n_ticks;
        r_num     <= n_num;
        r_hz      <= n_hz;
        r_prod    <= n_prod;
        r_touched <= n_touched;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/capacitive_touch_toggle.sv
// capacitive touch toggle on a relaxation oscillator pin.
// channels: i_in takes one pin sample per beat; o_out gives one result beat
// per sample, in order (pull select, led, measurement and baseline fields);
// i_cfg writes registers 0..4 (edges, rounds, clock_hz, touch, release),
// always ready, to be used only while no sample is in flight.
// a plain sample passes through the queue and the output register to o_out.
// a sample that completes a measurement waits on the 40-step bit-serial
// divider; the one that ends calibration runs that divider twice.
// throughput is one sample per cycle between measurements while o_out is
// not stalled.
// the front end keeps counting into a 4-entry queue while the back end
// divides, so samples keep being accepted until that queue fills.
// reset: registers return to their defaults, calibration restarts, led off.
// a stall on o_out holds the result register and backs up through the
// queue to i_in.ready.
// depends on cttog_pkg, cttog_stream_if and the cttog_* submodules
module capacitive_touch_toggle
    import cttog_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cttog_stream_if.sink   i_in,
    cttog_stream_if.source o_out,
    cttog_stream_if.sink   i_cfg
);

    t_cfg_regs r_cfg;
    t_q_entry  push_entry;
    t_q_entry  pop_entry;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_out_item out_data;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop_ready;
    logic      out_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{edges_per_measure: EDGES_RST,
                       calibration_rounds: ROUNDS_RST,
                       clock_hz: CLOCK_RST,
                       touch_fraction_q16: TOUCH_RST,
                       release_fraction_q16: RELEASE_RST};
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                CFG_EDGES:   r_cfg.edges_per_measure    <= i_cfg.data.wdata[EDGE_W-1:0];
                CFG_ROUNDS:  r_cfg.calibration_rounds   <= i_cfg.data.wdata[ROUND_W-1:0];
                CFG_CLOCK:   r_cfg.clock_hz             <= i_cfg.data.wdata[HZ_W-1:0];
                CFG_TOUCH:   r_cfg.touch_fraction_q16   <= i_cfg.data.wdata[FRAC_W-1:0];
                CFG_RELEASE: r_cfg.release_fraction_q16 <= i_cfg.data.wdata[FRAC_W-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    cttog_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in.valid),
        .i_in_level          (i_in.data.pin_level),
        .o_in_ready          (i_in.ready),
        .i_edges_per_measure (r_cfg.edges_per_measure),
        .o_push_valid        (push_valid),
        .o_push_entry        (push_entry),
        .i_push_ready        (push_ready)
    );

    cttog_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    cttog_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    cttog_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (o_out.ready)
    );

    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;

endmodule
